// File: hdl/eau_pkg.sv
// Package for the error-function pipeline: fixed-point formats, coefficients,
// side-band structs and the shared Q30 rounding helper. No dependencies.
package eau_pkg;

  localparam int FRAC_BITS = 16;

  localparam logic [30:0] Q_ONE = 31'h4000_0000;

  localparam logic signed [33:0] A1 = 34'sd273621191;
  localparam logic signed [33:0] A2 = -34'sd305476044;
  localparam logic signed [33:0] A3 = 34'sd1526231383;
  localparam logic signed [33:0] A4 = -34'sd1560310108;
  localparam logic signed [33:0] A5 = 34'sd1139675401;
  localparam logic [28:0] COEF_P = 29'd351748265;

  localparam logic signed [33:0] HORNER_ADD [5] = '{A4, A3, A2, A1, 34'sd0};

  localparam logic [31:0] RECIP5 = 32'd858993459;
  localparam logic [31:0] RECIP3 = 32'd1431655765;

  localparam int DEN_W = (54 - FRAC_BITS > 31) ? 54 - FRAC_BITS : 31;

  localparam int X_SHL = (FRAC_BITS <= 28) ? 28 - FRAC_BITS : 0;
  localparam int X_SHR = (FRAC_BITS > 28) ? FRAC_BITS - 28 : 0;
  localparam logic [54:0] X_RND = (55'd1 << X_SHR) >> 1;
  localparam logic [33:0] BIG_LIM = 34'd5 << FRAC_BITS;

  localparam int OUT_SH = 30 - FRAC_BITS;
  localparam logic [35:0] OUT_RND = (36'd1 << OUT_SH) >> 1;
  localparam logic [35:0] POS_LIM = (FRAC_BITS >= 17) ? 36'd131071 : (36'd1 << FRAC_BITS);
  localparam logic [35:0] NEG_LIM = (FRAC_BITS >= 17) ? 36'd131072 : (36'd1 << FRAC_BITS);

  localparam logic [1:0] CLS_FINITE  = 2'd0;
  localparam logic [1:0] CLS_NEG_INF = 2'd1;
  localparam logic [1:0] CLS_POS_INF = 2'd2;

  typedef struct packed {
    logic        neg;
    logic [1:0]  cls;
    logic        big;
    logic [23:0] ax;
  } x_side_t;

  typedef struct packed {
    logic        neg;
    logic [1:0]  cls;
    logic [30:0] e;
  } t_side_t;

  function automatic logic [33:0] round_q30(input logic [63:0] p);
    return 34'((p + 64'h2000_0000) >> 30);
  endfunction

endpackage

// File: hdl/eau_exp.sv
// Exponential stage chain: exp(-x*x) in Q30 by a short series on x*x/256
// followed by eight squarings. Depends on eau_pkg.
module eau_exp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              i_vld,
  input  eau_pkg::x_side_t  i_side,
  output logic              o_vld,
  output logic [30:0]       o_e,
  output eau_pkg::x_side_t  o_side
);
  import eau_pkg::*;

  localparam int NSTG = 29;

  logic [NSTG-1:0] v_r;
  x_side_t         side_r [NSTG];
  logic [26:0]     rr_r [10];

  logic [61:0] sq_r;
  logic [59:0] m2_r;
  logic [27:0] n2_r;
  logic [30:0] g3_r;
  logic [57:0] p4_r;
  logic [30:0] g5_r;
  logic [57:0] p6_r;
  logic [59:0] m7_r;
  logic [27:0] n7_r;
  logic [30:0] g8_r;
  logic [57:0] p9_r;
  logic [30:0] g10_r;
  logic [57:0] p11_r;
  logic [30:0] g12_r;
  logic [61:0] sp_r [8];
  logic [30:0] sg_r [8];

  logic [54:0] x_ext;
  logic [30:0] x28;
  logic [35:0] s1;
  logic [26:0] r1;
  logic [27:0] n2;
  logic [27:0] q3_0, rem3, q3;
  logic [27:0] u5, u7, n7, u10, u12;
  logic [27:0] q8_0, rem8, q8;

  always_comb begin
    x_ext = ((55'(i_side.ax) + X_RND) >> X_SHR) << X_SHL;
    x28   = x_ext[30:0];
    s1    = 36'((sq_r + (62'd1 << 25)) >> 26);
    r1    = 27'((s1 + 36'd128) >> 8);
    n2    = 28'(rr_r[0]) + 28'd2;
    q3_0  = 28'(m2_r >> 32);
    rem3  = n2_r - q3_0 - (q3_0 << 2);
    q3    = q3_0 + ((rem3 >= 28'd5) ? 28'd1 : 28'd0);
    u5    = 28'(round_q30(64'(p4_r)));
    u7    = 28'(round_q30(64'(p6_r)));
    n7    = u7 + 28'd1;
    q8_0  = 28'(m7_r >> 32);
    rem8  = n7_r - q8_0 - (q8_0 << 1);
    q8    = q8_0 + ((rem8 >= 28'd3) ? 28'd1 : 28'd0);
    u10   = 28'(round_q30(64'(p9_r)));
    u12   = 28'(round_q30(64'(p11_r)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NSTG-2:0], i_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= i_side;
      for (int k = 1; k < NSTG; k++) side_r[k] <= side_r[k-1];
      rr_r[0] <= r1;
      for (int k = 1; k < 10; k++) rr_r[k] <= rr_r[k-1];
      sq_r  <= 62'(x28) * 62'(x28);
      m2_r  <= 60'(n2) * 60'(RECIP5);
      n2_r  <= n2;
      g3_r  <= Q_ONE - 31'(q3);
      p4_r  <= 58'(rr_r[2]) * 58'(g3_r);
      g5_r  <= Q_ONE - 31'((u5 + 28'd2) >> 2);
      p6_r  <= 58'(rr_r[4]) * 58'(g5_r);
      m7_r  <= 60'(n7) * 60'(RECIP3);
      n7_r  <= n7;
      g8_r  <= Q_ONE - 31'(q8);
      p9_r  <= 58'(rr_r[7]) * 58'(g8_r);
      g10_r <= Q_ONE - 31'((u10 + 28'd1) >> 1);
      p11_r <= 58'(rr_r[9]) * 58'(g10_r);
      g12_r <= Q_ONE - 31'(u12);
    end
  end

  for (genvar j = 0; j < 8; j++) begin : g_sq
    logic [30:0] gin;
    if (j == 0) begin : g_first
      assign gin = g12_r;
    end else begin : g_next
      assign gin = sg_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sp_r[j] <= 62'(gin) * 62'(gin);
        sg_r[j] <= 31'(round_q30(64'(sp_r[j])));
      end
    end
  end

  assign o_vld  = v_r[NSTG-1];
  assign o_side = side_r[NSTG-1];
  assign o_e    = side_r[NSTG-1].big ? 31'd0 : sg_r[7];

endmodule

// File: hdl/eau_recip.sv
// Reciprocal stage chain: t = round(2^60 / (2^30 + p|x|)) by a multiply,
// then a restoring divider with one quotient bit per stage. Depends on eau_pkg.
module eau_recip (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              i_vld,
  input  logic [23:0]       i_ax,
  input  eau_pkg::t_side_t  i_side,
  output logic              o_vld,
  output logic [30:0]       o_t,
  output eau_pkg::t_side_t  o_side
);
  import eau_pkg::*;

  localparam int NSTG = 33;

  logic [NSTG-1:0]  v_r;
  t_side_t          side_r [NSTG];
  logic [52:0]      pm_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r [31];
  logic [DEN_W-1:0] dd_r [31];
  logic [30:0]      q_r [31];
  logic [52:0]      px;

  assign px = (pm_r + (53'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NSTG-2:0], i_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= i_side;
      for (int k = 1; k < NSTG; k++) side_r[k] <= side_r[k-1];
      pm_r  <= 53'(COEF_P) * 53'(i_ax);
      den_r <= DEN_W'(Q_ONE) + DEN_W'(px);
    end
  end

  for (genvar k = 0; k < 31; k++) begin : g_div
    logic [DEN_W-1:0] rin, din, dsh;
    logic [30:0]      qin;
    logic [DEN_W:0]   rem2;
    logic             ge;
    if (k == 0) begin : g_first
      assign rin = DEN_W'(30'h2000_0000) + (den_r >> 32);
      assign din = den_r;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_r[k-1];
      assign din = dd_r[k-1];
      assign qin = q_r[k-1];
    end
    assign dsh  = din >> (31 - k);
    assign rem2 = {rin, dsh[0]};
    assign ge   = rem2 >= {1'b0, din};
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= ge ? DEN_W'(rem2 - {1'b0, din}) : DEN_W'(rem2);
        dd_r[k]  <= din;
        q_r[k]   <= {qin[29:0], ge};
      end
    end
  end

  assign o_vld  = v_r[NSTG-1];
  assign o_side = side_r[NSTG-1];
  assign o_t    = q_r[30];

endmodule

// File: hdl/eau_poly.sv
// Horner polynomial in t over the five coefficients, two stages per step:
// sign-magnitude multiply, then round and add. Depends on eau_pkg.
module eau_poly (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               i_vld,
  input  logic [30:0]        i_t,
  input  eau_pkg::t_side_t   i_side,
  output logic               o_vld,
  output logic signed [33:0] o_h,
  output eau_pkg::t_side_t   o_side
);
  import eau_pkg::*;

  localparam int NSTG = 10;

  logic [NSTG-1:0]    v_r;
  t_side_t            side_r [NSTG];
  logic [30:0]        tt_r [NSTG];
  logic [63:0]        hm_r [5];
  logic               hs_r [5];
  logic signed [33:0] h_r [5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NSTG-2:0], i_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= i_side;
      tt_r[0]   <= i_t;
      for (int k = 1; k < NSTG; k++) begin
        side_r[k] <= side_r[k-1];
        tt_r[k]   <= tt_r[k-1];
      end
    end
  end

  for (genvar j = 0; j < 5; j++) begin : g_step
    logic signed [33:0] h_in;
    logic [30:0]        t_in;
    logic [32:0]        mag;
    logic [33:0]        rq;
    logic signed [33:0] sval;
    if (j == 0) begin : g_first
      assign h_in = A5;
      assign t_in = i_t;
    end else begin : g_next
      assign h_in = h_r[j-1];
      assign t_in = tt_r[2*j-1];
    end
    assign mag  = 33'(h_in[33] ? -h_in : h_in);
    assign rq   = round_q30(hm_r[j]);
    assign sval = hs_r[j] ? -$signed(rq) : $signed(rq);
    always_ff @(posedge clk) begin
      if (adv) begin
        hm_r[j] <= 64'(mag) * 64'(t_in);
        hs_r[j] <= h_in[33];
        h_r[j]  <= sval + HORNER_ADD[j];
      end
    end
  end

  assign o_vld  = v_r[NSTG-1];
  assign o_side = side_r[NSTG-1];
  assign o_h    = h_r[4];

endmodule

// File: hdl/erf_approximation_unit.sv
// Top level of the error-function pipeline: input register, exp, reciprocal
// and polynomial chains, final combine and output register. Depends on eau_pkg.
//
// Computes erf(x) on signed fixed point with FRAC_BITS fraction bits using
// the five-coefficient rational-exponential form, saturated to +/-1; class
// minus or plus infinity returns exactly -1 or +1. One request is taken per
// cycle while not stalled; each result passes one input register, 29 stages
// for exp(-x*x) (series plus eight squarings), 33 for the reciprocal (one
// multiply, the denominator and a 31-step restoring divider, one quotient bit
// per stage), 10 for the Horner polynomial and 3 for the final product,
// rounding and output register. A stalled output holds the whole pipeline.
module erf_approximation_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_arg_value,
  input  logic [1:0]         in_arg_class,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] out_erf_value
);
  import eau_pkg::*;

  logic adv;

  logic    vin_r;
  x_side_t in_side_r;
  x_side_t in_side;
  logic [23:0] ax_in;

  logic        exp_vld;
  logic [30:0] exp_e;
  x_side_t     exp_side;
  t_side_t     rc_side_in;

  logic        rc_vld;
  logic [30:0] rc_t;
  t_side_t     rc_side;

  logic               pl_vld;
  logic signed [33:0] pl_h;
  t_side_t            pl_side;

  logic        f1_v_r, f1_fs_r, f1_neg_r;
  logic [1:0]  f1_cls_r;
  logic [63:0] f1_m_r;
  logic        f2_v_r;
  logic [1:0]  f2_cls_r;
  logic signed [35:0] f2_y_r;
  logic        out_valid_r;
  logic signed [17:0] out_erf_value_r;

  logic [32:0]        h_mag;
  logic [33:0]        he_r;
  logic signed [35:0] he_s, y_pos, y_nxt;
  logic [35:0]        y_mag, y_rnd, mag_c;
  logic signed [17:0] out_nxt;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_comb begin
    ax_in        = in_arg_value[23] ? 24'(-in_arg_value) : 24'(in_arg_value);
    in_side.neg  = in_arg_value[23];
    in_side.cls  = in_arg_class;
    in_side.ax   = ax_in;
    in_side.big  = {10'd0, ax_in} >= BIG_LIM;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vin_r       <= 1'b0;
      f1_v_r      <= 1'b0;
      f2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vin_r       <= in_valid;
      f1_v_r      <= pl_vld;
      f2_v_r      <= f1_v_r;
      out_valid_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_side_r <= in_side;
    end
  end

  eau_exp u_exp (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .i_vld  (vin_r),
    .i_side (in_side_r),
    .o_vld  (exp_vld),
    .o_e    (exp_e),
    .o_side (exp_side)
  );

  always_comb begin
    rc_side_in.neg = exp_side.neg;
    rc_side_in.cls = exp_side.cls;
    rc_side_in.e   = exp_e;
  end

  eau_recip u_recip (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .i_vld  (exp_vld),
    .i_ax   (exp_side.ax),
    .i_side (rc_side_in),
    .o_vld  (rc_vld),
    .o_t    (rc_t),
    .o_side (rc_side)
  );

  eau_poly u_poly (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .i_vld  (rc_vld),
    .i_t    (rc_t),
    .i_side (rc_side),
    .o_vld  (pl_vld),
    .o_h    (pl_h),
    .o_side (pl_side)
  );

  always_comb begin
    h_mag = 33'(pl_h[33] ? -pl_h : pl_h);
    he_r  = round_q30(f1_m_r);
    he_s  = f1_fs_r ? -$signed(36'(he_r)) : $signed(36'(he_r));
    y_pos = $signed(36'(Q_ONE)) - he_s;
    y_nxt = f1_neg_r ? -y_pos : y_pos;
    y_mag = 36'(f2_y_r[35] ? -f2_y_r : f2_y_r);
    y_rnd = (y_mag + OUT_RND) >> OUT_SH;
    if (f2_y_r[35]) begin
      mag_c   = (y_rnd > NEG_LIM) ? NEG_LIM : y_rnd;
      out_nxt = -$signed(18'(mag_c));
    end else begin
      mag_c   = (y_rnd > POS_LIM) ? POS_LIM : y_rnd;
      out_nxt = $signed(18'(mag_c));
    end
    case (f2_cls_r)
      CLS_NEG_INF: out_nxt = -$signed(18'(NEG_LIM));
      CLS_POS_INF: out_nxt = $signed(18'(POS_LIM));
      CLS_FINITE:  ;
      default:     ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_m_r          <= 64'(h_mag) * 64'(pl_side.e);
      f1_fs_r         <= pl_h[33];
      f1_neg_r        <= pl_side.neg;
      f1_cls_r        <= pl_side.cls;
      f2_y_r          <= y_nxt;
      f2_cls_r        <= f1_cls_r;
      out_erf_value_r <= out_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_erf_value = out_erf_value_r;

endmodule

// File: dv/tb_erf_approximation_unit.sv
// Testbench for erf_approximation_unit: directed and random arguments, each result
// checked against a Q30 fixed-point erf predictor held in a small scoreboard class.
// Depends on eau_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_erf_approximation_unit;
  import eau_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;

  class erf_scoreboard;
    logic signed [17:0] pending[$];
    int unsigned errors;

    function logic [63:0] mul_q30(logic [63:0] a, logic [63:0] b);
      return (a * b + 64'd536870912) >> 30;
    endfunction

    function longint smul_q30(longint a, logic [63:0] b);
      logic [63:0] m;
      m = (a < 0) ? 64'(-a) : 64'(a);
      m = mul_q30(m, b);
      return (a < 0) ? -longint'(m) : longint'(m);
    endfunction

    function logic [63:0] exp_neg(logic [63:0] s);
      logic [63:0] r;
      logic [63:0] g;
      r = (s + 64'd128) >> 8;
      g = 64'(Q_ONE) - (r + 64'd2) / 64'd5;
      g = 64'(Q_ONE) - (mul_q30(r, g) + 64'd2) / 64'd4;
      g = 64'(Q_ONE) - (mul_q30(r, g) + 64'd1) / 64'd3;
      g = 64'(Q_ONE) - (mul_q30(r, g) + 64'd1) / 64'd2;
      g = 64'(Q_ONE) - mul_q30(r, g);
      for (int i = 0; i < 8; i++) g = mul_q30(g, g);
      return g;
    endfunction

    function longint clamp_field(longint v);
      longint one;
      one = longint'(1) << FRAC_BITS;
      if (v > one) v = one;
      if (v < -one) v = -one;
      if (v > 131071) v = 131071;
      if (v < -131072) v = -131072;
      return v;
    endfunction

    function logic signed [17:0] erf_fixed(logic [23:0] arg, logic [1:0] cls);
      logic neg;
      logic [63:0] ax;
      logic [63:0] px;
      logic [63:0] den;
      logic [63:0] t;
      logic [63:0] e;
      logic [63:0] x28;
      logic [63:0] mag;
      longint h;
      longint y;
      longint res;
      neg = arg[23];
      ax = neg ? 64'h100_0000 - 64'(arg) : 64'(arg);
      if (cls == CLS_NEG_INF) return 18'(clamp_field(-(longint'(1) << FRAC_BITS)));
      if (cls == CLS_POS_INF) return 18'(clamp_field(longint'(1) << FRAC_BITS));
      px = (64'(COEF_P) * ax + ((64'd1 << FRAC_BITS) >> 1)) >> FRAC_BITS;
      den = 64'(Q_ONE) + px;
      t = ((64'd1 << 60) + den / 2) / den;
      h = A5;
      h = smul_q30(h, t) + A4;
      h = smul_q30(h, t) + A3;
      h = smul_q30(h, t) + A2;
      h = smul_q30(h, t) + A1;
      h = smul_q30(h, t);
      if (ax >= (64'd5 << FRAC_BITS)) begin
        e = 0;
      end else begin
        if (FRAC_BITS <= 28) x28 = ax << X_SHL;
        else x28 = (ax + 64'(X_RND)) >> X_SHR;
        e = exp_neg((x28 * x28 + (64'd1 << 25)) >> 26);
      end
      y = longint'(Q_ONE) - smul_q30(h, e);
      if (neg) y = -y;
      mag = (y < 0) ? 64'(-y) : 64'(y);
      if (OUT_SH > 0) mag = (mag + ((64'd1 << OUT_SH) >> 1)) >> OUT_SH;
      if (mag > (64'd1 << 20)) mag = 64'd1 << 20;
      res = (y < 0) ? -longint'(mag) : longint'(mag);
      return 18'(clamp_field(res));
    endfunction

    function void note_request(logic [23:0] arg, logic [1:0] cls);
      pending.push_back(erf_fixed(arg, cls));
    endfunction

    function bit check_result(logic signed [17:0] got, output logic signed [17:0] want);
      want = 'x;
      if (pending.size() == 0) return 0;
      want = pending.pop_front();
      return got === want;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [23:0] in_arg_value = '0;
  logic [1:0] in_arg_class = CLS_FINITE;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [17:0] out_erf_value;

  erf_scoreboard sb = new();
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit recv_started = 1'b0;

  erf_approximation_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_arg_value(in_arg_value), .in_arg_class(in_arg_class),
    .out_valid(out_valid), .out_stall(out_stall), .out_erf_value(out_erf_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic signed [17:0] want;
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_request(in_arg_value, in_arg_class);
      if (out_valid && !out_stall) begin
        if (sb.pending.size() == 0)
          report_mismatch($sformatf("unexpected result %0d", out_erf_value));
        else if (!sb.check_result(out_erf_value, want))
          report_mismatch($sformatf("erf_value got %0d want %0d", out_erf_value, want));
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (recv_started) out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_request(logic [23:0] arg, logic [1:0] cls);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_arg_value <= arg;
    in_arg_class <= cls;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random;
    int unsigned k;
    logic [23:0] v;
    logic [1:0] c;
    k = $urandom_range(99);
    v = 24'($urandom);
    if (k < 50) v = 24'(int'($urandom_range(393216)) * ($urandom_range(1) ? 1 : -1));
    else if (k < 65) v = 24'(int'($urandom_range(1023)) * ($urandom_range(1) ? 1 : -1));
    else if (k < 75) v = 24'(int'(5 << FRAC_BITS) + int'($urandom_range(3)) - 2);
    c = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : CLS_FINITE;
    send_request(v, c);
  endtask

  initial begin
    logic [23:0] directed[$];
    directed = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF, 24'h800000,
                 24'h010000, 24'hFF0000, 24'h04FFFF, 24'h050000, 24'hFB0000,
                 24'hFB0001, 24'h008000, 24'h555555, 24'hAAAAAA, 24'h000100};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    recv_started = 1'b1;
    foreach (directed[i]) send_request(directed[i], CLS_FINITE);
    send_request(24'h123456, CLS_NEG_INF);
    send_request(24'h800000, CLS_POS_INF);
    send_request(24'h000000, CLS_NEG_INF);
    send_request(24'h7FFFFF, 2'd3);
    send_request(24'h800000, 2'd3);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 54 : 0;
      recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 32 : 0;
      repeat (530) send_random();
    end
    in_valid <= 1'b0;
    recv_idle_pct = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && sb.pending.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

// File: filelist.f
hdl/eau_pkg.sv
hdl/eau_exp.sv
hdl/eau_recip.sv
hdl/eau_poly.sv
hdl/erf_approximation_unit.sv
dv/tb_erf_approximation_unit.sv
